// ===== design/scpr_pkg.sv =====
// shared types and constants of the second-chance page replacer
package scpr_pkg;

   // reference opcodes in address bits 7:6
   localparam logic [1:0] OP_ADD   = 2'b00;
   localparam logic [1:0] OP_SUB   = 2'b01;
   localparam logic [1:0] OP_WRITE = 2'b10;

   // csr map: one register every four bytes
   localparam int         PADDR_W           = 3;
   localparam logic       CSR_OFFSET_BITS   = 1'b0;
   localparam logic       CSR_FRAMES_IN_USE = 1'b1;
   localparam logic [4:0] OFFSET_BITS_RESET   = 5'd12;
   localparam logic [6:0] FRAMES_IN_USE_RESET = 7'd64;

   // controller states
   typedef enum logic [2:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_LK_RD,
      ST_LK_CMP,
      ST_WK_RD,
      ST_WK_CHK,
      ST_DONE
   } state_type;

   // per-frame flags held in the flag memory
   typedef struct packed {
      logic valid;
      logic refb;
      logic dirty;
   } flags_type;

   // controller to datapath
   typedef struct packed {
      logic clr_wr;    // clearing pass: zero flags at the counter
      logic start;     // take a new reference
      logic lk_next;   // lookup moves to the next frame
      logic lk_hit;    // lookup hit: set reference, and dirty on a write
      logic wk_start;  // miss: count fault, start the walk past the hand
      logic wk_clear;  // hand passes a referenced frame
      logic wk_fill;   // hand takes the victim frame
      logic out_load;  // load the result register
   } cmd_type;

   // datapath to controller
   typedef struct packed {
      logic clr_last;
      logic match;
      logic lk_last;
      logic wk_take;
      logic out_free;
   } sts_type;

endpackage

// ===== design/scpr_ifs.sv =====
// handshake channels of the page replacer: reference in, result out
interface scpr_req_if;
   logic        valid;
   logic        ready;
   logic [31:0] address;

   modport source (output valid, output address, input ready);
   modport sink (input valid, input address, output ready);
endinterface

interface scpr_rsp_if;
   logic               valid;
   logic               ready;
   logic               hit;
   logic [5:0]         frame;
   logic               flushed;
   logic [31:0]        page_number;
   logic [31:0]        fault_count;
   logic [31:0]        write_count;
   logic [31:0]        flush_count;
   logic signed [31:0] accumulator;

   modport source (output valid, output hit, output frame, output flushed,
                   output page_number, output fault_count, output write_count,
                   output flush_count, output accumulator, input ready);
   modport sink (input valid, input hit, input frame, input flushed,
                 input page_number, input fault_count, input write_count,
                 input flush_count, input accumulator, output ready);
endinterface

// ===== design/second_chance_page_replacer_unit.sv =====
// top level of the second-chance page replacer: csr port, controller, datapath

// Each reference on req_bus is looked up against the frames in use by
// scanning a single-port tag memory and flag memory one frame at a time,
// with a read state and a compare state per frame because the read data is
// registered. A hit in frame k ends the scan there; a miss scans all n
// active frames and then walks the clock hand, clearing each referenced
// frame it passes until it takes its victim. One reference is worked on at
// a time; the next is taken while the previous result waits in the output
// register. After reset a clearing pass zeroes the flags of all FRAMES
// frames, and no reference is taken until it ends (csr writes are taken
// throughout). Register 0 at byte address 0 is offset_bits, register 1 at
// byte address 4 is frames_in_use.
module second_chance_page_replacer_unit #(
   parameter int FRAMES = 64
) (
   input  logic                           clock,
   input  logic                           reset,
   scpr_req_if.sink                       req_bus,
   scpr_rsp_if.source                     rsp_bus,
   input  logic                           psel,
   input  logic                           penable,
   input  logic                           pwrite,
   input  logic [scpr_pkg::PADDR_W-1:0]   paddr,
   input  logic [31:0]                    pwdata,
   output logic [31:0]                    prdata,
   output logic                           pready
);

   logic [4:0]        offset_bits_ff;
   logic [6:0]        frames_in_use_ff;
   logic              csr_wr;
   logic              ctl_ready;
   scpr_pkg::cmd_type cmd;
   scpr_pkg::sts_type sts;

   // csr write and read
   assign pready = 1'b1;
   assign csr_wr = psel && penable && pwrite;

   always_ff @(posedge clock) begin
      if (reset) begin
         offset_bits_ff   <= scpr_pkg::OFFSET_BITS_RESET;
         frames_in_use_ff <= scpr_pkg::FRAMES_IN_USE_RESET;
      end else if (csr_wr) begin
         unique case (paddr[2])
            scpr_pkg::CSR_OFFSET_BITS:   offset_bits_ff   <= pwdata[4:0];
            scpr_pkg::CSR_FRAMES_IN_USE: frames_in_use_ff <= pwdata[6:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      unique case (paddr[2])
         scpr_pkg::CSR_OFFSET_BITS:   prdata = {27'd0, offset_bits_ff};
         scpr_pkg::CSR_FRAMES_IN_USE: prdata = {25'd0, frames_in_use_ff};
         default:                     prdata = '0;
      endcase
   end

   // controller
   scpr_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_bus.valid),
      .req_ready (ctl_ready),
      .sts       (sts),
      .cmd       (cmd)
   );

   assign req_bus.ready = ctl_ready;

   // datapath
   scpr_dpath #(
      .FRAMES (FRAMES)
   ) u_dpath (
      .clock         (clock),
      .reset         (reset),
      .cmd           (cmd),
      .sts           (sts),
      .req_address   (req_bus.address),
      .offset_bits   (offset_bits_ff),
      .frames_in_use (frames_in_use_ff),
      .rsp           (rsp_bus)
   );

   // no transfer in during the clearing pass that follows reset
   a_clear_blocks: assert property (@(posedge clock)
      reset |=> !req_bus.ready)
      else $error("reference taken during clearing pass");

   // a taken reference keeps the input closed on the next cycle
   a_busy_after_start: assert property (@(posedge clock) disable iff (reset)
      cmd.start |=> !req_bus.ready)
      else $error("input open while a reference is at work");

   // a result is never loaded over one not yet taken
   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      cmd.out_load |-> sts.out_free)
      else $error("result register overwritten");

   // a resident page never causes an eviction
   a_hit_no_flush: assert property (@(posedge clock) disable iff (reset)
      rsp_bus.valid && rsp_bus.hit |-> !rsp_bus.flushed)
      else $error("flush reported on a hit");

endmodule

// ===== design/scpr_ctrl.sv =====
// controller state machine: clearing pass, lookup scan, clock-hand walk
module scpr_ctrl (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_ready,
   input  scpr_pkg::sts_type sts,
   output scpr_pkg::cmd_type cmd
);

   scpr_pkg::state_type state_ff, state_in;

   // state register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= scpr_pkg::ST_CLEAR;
      end else begin
         state_ff <= state_in;
      end
   end

   // next state and commands
   always_comb begin
      state_in  = state_ff;
      cmd       = '0;
      req_ready = 1'b0;
      unique case (state_ff)
         scpr_pkg::ST_CLEAR: begin
            cmd.clr_wr = 1'b1;
            if (sts.clr_last) begin
               state_in = scpr_pkg::ST_IDLE;
            end
         end
         scpr_pkg::ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.start = 1'b1;
               state_in  = scpr_pkg::ST_LK_RD;
            end
         end
         scpr_pkg::ST_LK_RD: begin
            state_in = scpr_pkg::ST_LK_CMP;
         end
         scpr_pkg::ST_LK_CMP: begin
            if (sts.match) begin
               cmd.lk_hit = 1'b1;
               state_in   = scpr_pkg::ST_DONE;
            end else if (sts.lk_last) begin
               cmd.wk_start = 1'b1;
               state_in     = scpr_pkg::ST_WK_RD;
            end else begin
               cmd.lk_next = 1'b1;
               state_in    = scpr_pkg::ST_LK_RD;
            end
         end
         scpr_pkg::ST_WK_RD: begin
            state_in = scpr_pkg::ST_WK_CHK;
         end
         scpr_pkg::ST_WK_CHK: begin
            if (sts.wk_take) begin
               cmd.wk_fill = 1'b1;
               state_in    = scpr_pkg::ST_DONE;
            end else begin
               cmd.wk_clear = 1'b1;
               state_in     = scpr_pkg::ST_WK_RD;
            end
         end
         scpr_pkg::ST_DONE: begin
            if (sts.out_free) begin
               cmd.out_load = 1'b1;
               state_in     = scpr_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = scpr_pkg::ST_IDLE;
         end
      endcase
   end

endmodule

// ===== design/scpr_dpath.sv =====
// datapath: page and flag memories, clock hand, totals and result register
module scpr_dpath #(
   parameter int FRAMES = 64
) (
   input  logic              clock,
   input  logic              reset,
   input  scpr_pkg::cmd_type cmd,
   output scpr_pkg::sts_type sts,
   input  logic [31:0]       req_address,
   input  logic [4:0]        offset_bits,
   input  logic [6:0]        frames_in_use,
   scpr_rsp_if.source        rsp
);

   localparam int IDXW = (FRAMES > 1) ? $clog2(FRAMES) : 1;
   localparam int CNTW = $clog2(FRAMES + 1);

   // memories
   logic [31:0]         pg_mem [FRAMES];
   scpr_pkg::flags_type fl_mem [FRAMES];
   logic [31:0]         pg_rd_ff;
   scpr_pkg::flags_type fl_rd_ff;
   scpr_pkg::flags_type fl_wdata;
   logic                fl_we;

   // item and walk state
   logic [IDXW-1:0] cnt_ff, cnt_in;
   logic [IDXW-1:0] hand_ff;
   logic            hand_started_ff;
   logic            has_start_ff;
   logic [CNTW-1:0] n_ff, n_in;
   logic [31:0]     page_ff;
   logic            write_ff;
   logic            hit_ff;
   logic            flushed_ff;
   logic [31:0]     faults_ff, writes_ff, flushes_ff, acc_ff;
   logic [1:0]      op;
   logic [CNTW-1:0] cnt_inc, hand_inc;
   logic [IDXW-1:0] cnt_adv, hand_adv;

   // result register
   logic            rsp_valid_ff;
   logic            rsp_hit_ff;
   logic [5:0]      rsp_frame_ff;
   logic            rsp_flushed_ff;
   logic [31:0]     rsp_page_ff, rsp_faults_ff, rsp_writes_ff, rsp_flushes_ff;
   logic [31:0]     rsp_acc_ff;

   assign op = req_address[7:6];

   // active frame count, clamped to one .. FRAMES
   always_comb begin
      if (frames_in_use == 7'd0) begin
         n_in = CNTW'(1);
      end else if (32'(frames_in_use) > 32'(FRAMES)) begin
         n_in = CNTW'(FRAMES);
      end else begin
         n_in = CNTW'(frames_in_use);
      end
   end

   // wrap-around step for the counter and for the hand
   always_comb begin
      cnt_inc  = CNTW'(cnt_ff) + CNTW'(1);
      hand_inc = CNTW'(hand_ff) + CNTW'(1);
      cnt_adv  = (cnt_inc >= n_ff) ? '0 : IDXW'(cnt_inc);
      hand_adv = (hand_inc >= n_ff) ? '0 : IDXW'(hand_inc);
   end

   // flag write data
   always_comb begin
      fl_we    = cmd.clr_wr | cmd.lk_hit | cmd.wk_clear | cmd.wk_fill;
      fl_wdata = '0;
      if (cmd.lk_hit) begin
         fl_wdata.valid = 1'b1;
         fl_wdata.refb  = 1'b1;
         fl_wdata.dirty = fl_rd_ff.dirty | write_ff;
      end else if (cmd.wk_clear) begin
         fl_wdata.valid = fl_rd_ff.valid;
         fl_wdata.refb  = 1'b0;
         fl_wdata.dirty = fl_rd_ff.dirty;
      end else if (cmd.wk_fill) begin
         fl_wdata.valid = 1'b1;
         fl_wdata.refb  = 1'b1;
         fl_wdata.dirty = write_ff;
      end
   end

   // memory ports: one address, registered read
   always_ff @(posedge clock) begin
      if (cmd.wk_fill) begin
         pg_mem[cnt_ff] <= page_ff;
      end
      if (fl_we) begin
         fl_mem[cnt_ff] <= fl_wdata;
      end
      pg_rd_ff <= pg_mem[cnt_ff];
      fl_rd_ff <= fl_mem[cnt_ff];
   end

   // frame counter
   always_comb begin
      cnt_in = cnt_ff;
      if (cmd.clr_wr || cmd.lk_next) begin
         cnt_in = IDXW'(cnt_inc);
      end else if (cmd.start) begin
         cnt_in = '0;
      end else if (cmd.wk_start) begin
         cnt_in = hand_started_ff ? hand_adv : '0;
      end else if (cmd.wk_clear) begin
         cnt_in = cnt_adv;
      end
   end

   // control state: counter, hand and totals
   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff          <= '0;
         hand_ff         <= '0;
         hand_started_ff <= 1'b0;
         faults_ff       <= '0;
         writes_ff       <= '0;
         flushes_ff      <= '0;
         acc_ff          <= '0;
      end else begin
         cnt_ff <= cnt_in;
         if (cmd.start) begin
            case (op)
               scpr_pkg::OP_ADD:   acc_ff <= acc_ff + {26'd0, req_address[5:0]};
               scpr_pkg::OP_SUB:   acc_ff <= acc_ff - {26'd0, req_address[5:0]};
               scpr_pkg::OP_WRITE: begin
                  if (writes_ff != '1) begin
                     writes_ff <= writes_ff + 32'd1;
                  end
               end
               default: ;
            endcase
         end
         if (cmd.wk_start && faults_ff != '1) begin
            faults_ff <= faults_ff + 32'd1;
         end
         if (cmd.wk_fill) begin
            hand_ff         <= cnt_ff;
            hand_started_ff <= 1'b1;
            if (fl_rd_ff.dirty && flushes_ff != '1) begin
               flushes_ff <= flushes_ff + 32'd1;
            end
         end
      end
   end

   // per-item payload
   always_ff @(posedge clock) begin
      if (cmd.start) begin
         page_ff    <= req_address >> offset_bits;
         write_ff   <= (op == scpr_pkg::OP_WRITE);
         n_ff       <= n_in;
         hit_ff     <= 1'b0;
         flushed_ff <= 1'b0;
      end
      if (cmd.wk_start) begin
         has_start_ff <= hand_started_ff && (CNTW'(hand_ff) < n_ff);
      end
      if (cmd.lk_hit) begin
         hit_ff <= 1'b1;
      end
      if (cmd.wk_fill) begin
         flushed_ff <= fl_rd_ff.dirty;
      end
   end

   // status
   always_comb begin
      sts.clr_last = (cnt_ff == IDXW'(FRAMES - 1));
      sts.match    = fl_rd_ff.valid && (pg_rd_ff == page_ff);
      sts.lk_last  = (cnt_inc == n_ff);
      sts.wk_take  = !fl_rd_ff.refb || (has_start_ff && (cnt_ff == hand_ff));
      sts.out_free = !rsp_valid_ff || rsp.ready;
   end

   // result register, taken while the next reference is at work
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.out_load) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp.ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.out_load) begin
         rsp_hit_ff     <= hit_ff;
         rsp_frame_ff   <= 6'(cnt_ff);
         rsp_flushed_ff <= flushed_ff;
         rsp_page_ff    <= page_ff;
         rsp_faults_ff  <= faults_ff;
         rsp_writes_ff  <= writes_ff;
         rsp_flushes_ff <= flushes_ff;
         rsp_acc_ff     <= acc_ff;
      end
   end

   assign rsp.valid       = rsp_valid_ff;
   assign rsp.hit         = rsp_hit_ff;
   assign rsp.frame       = rsp_frame_ff;
   assign rsp.flushed     = rsp_flushed_ff;
   assign rsp.page_number = rsp_page_ff;
   assign rsp.fault_count = rsp_faults_ff;
   assign rsp.write_count = rsp_writes_ff;
   assign rsp.flush_count = rsp_flushes_ff;
   assign rsp.accumulator = signed'(rsp_acc_ff);

endmodule

// ===== bench/tb_second_chance_page_replacer_unit.sv =====
// self-checking bench for the second-chance page replacer: queued stimulus, predictor, checker
module tb_second_chance_page_replacer_unit;

   localparam int FRAMES = 64;
   localparam int HOLD_CYCLES = 400;
   localparam int DRAIN_CYCLES = 300;
   localparam logic [scpr_pkg::PADDR_W-1:0] ADDR_OFFSET_BITS =
      scpr_pkg::PADDR_W'({scpr_pkg::CSR_OFFSET_BITS, 2'b00});
   localparam logic [scpr_pkg::PADDR_W-1:0] ADDR_FRAMES_IN_USE =
      scpr_pkg::PADDR_W'({scpr_pkg::CSR_FRAMES_IN_USE, 2'b00});

   typedef struct packed {
      logic               hit;
      logic [5:0]         frame;
      logic               flushed;
      logic [31:0]        page_number;
      logic [31:0]        fault_count;
      logic [31:0]        write_count;
      logic [31:0]        flush_count;
      logic signed [31:0] accumulator;
   } page_result_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic psel;
   logic penable;
   logic pwrite;
   logic [scpr_pkg::PADDR_W-1:0] paddr;
   logic [31:0] pwdata;
   logic [31:0] prdata;
   logic pready;

   scpr_req_if req_bus ();
   scpr_rsp_if rsp_bus ();

   second_chance_page_replacer_unit #(.FRAMES(FRAMES)) dut (
      .clock   (clock),
      .reset   (reset),
      .req_bus (req_bus),
      .rsp_bus (rsp_bus),
      .psel    (psel),
      .penable (penable),
      .pwrite  (pwrite),
      .paddr   (paddr),
      .pwdata  (pwdata),
      .prdata  (prdata),
      .pready  (pready)
   );

   always #4 clock = ~clock;

   // stimulus and scoreboard bookkeeping
   logic [31:0]     pending_refs[$];
   page_result_type expected_results[$];
   int refs_queued = 0;
   int refs_accepted = 0;
   int results_checked = 0;
   int hits_seen = 0;
   int flushes_seen = 0;
   int mismatch_count = 0;
   logic req_fire = 1'b0;
   logic quiet = 1'b0;
   int holds_asked = 0;
   int holds_served = 0;
   int hold_left = 0;

   // predictor state: configuration and frame table
   logic [4:0]  cfg_offset_bits = scpr_pkg::OFFSET_BITS_RESET;
   logic [6:0]  cfg_frames = scpr_pkg::FRAMES_IN_USE_RESET;
   bit          frame_used [FRAMES];
   logic [31:0] frame_tag  [FRAMES];
   bit          ref_flag   [FRAMES];
   bit          dirty_flag [FRAMES];
   int          clock_hand = 0;
   bit          hand_placed = 1'b0;
   logic [31:0] faults_total = '0;
   logic [31:0] writes_total = '0;
   logic [31:0] flushes_total = '0;
   logic [31:0] acc_total = '0;

   function automatic logic [31:0] saturating_inc(input logic [31:0] v);
      return (v == 32'hFFFF_FFFF) ? v : v + 32'd1;
   endfunction

   function automatic int usable_frames(input logic [6:0] frames);
      if (frames == 0) return 1;
      if (frames > FRAMES) return FRAMES;
      return int'(frames);
   endfunction

   // one reference through the frame table: lookup, then clock sweep on a miss
   function automatic page_result_type predict_reference(input logic [31:0] addr);
      page_result_type r;
      logic [31:0] page;
      int n;
      int pos;
      int start;
      int steps;
      bit is_write;
      bit has_start;
      r = '0;
      page = addr >> cfg_offset_bits;
      n = usable_frames(cfg_frames);
      is_write = 1'b0;
      case (addr[7:6])
         scpr_pkg::OP_ADD: acc_total = acc_total + 32'(addr[5:0]);
         scpr_pkg::OP_SUB: acc_total = acc_total - 32'(addr[5:0]);
         scpr_pkg::OP_WRITE: begin
            writes_total = saturating_inc(writes_total);
            is_write = 1'b1;
         end
         default: ;
      endcase
      // lowest matching frame wins
      for (int i = 0; i < n; i++) begin
         if (frame_used[i] && frame_tag[i] == page) begin
            r.hit = 1'b1;
            r.frame = 6'(i);
            ref_flag[i] = 1'b1;
            if (is_write) dirty_flag[i] = 1'b1;
            break;
         end
      end
      if (!r.hit) begin
         has_start = hand_placed && clock_hand < n;
         start = clock_hand;
         pos = !hand_placed ? 0 : (clock_hand + 1 >= n) ? 0 : clock_hand + 1;
         steps = 0;
         faults_total = saturating_inc(faults_total);
         // sweep, clearing reference flags, until an unreferenced frame or the start
         while (ref_flag[pos] && steps <= n) begin
            if (has_start && pos == start) break;
            ref_flag[pos] = 1'b0;
            pos = (pos + 1 >= n) ? 0 : pos + 1;
            steps++;
         end
         if (dirty_flag[pos]) begin
            r.flushed = 1'b1;
            flushes_total = saturating_inc(flushes_total);
         end
         dirty_flag[pos] = is_write;
         ref_flag[pos] = 1'b1;
         frame_tag[pos] = page;
         frame_used[pos] = 1'b1;
         clock_hand = pos;
         hand_placed = 1'b1;
         r.frame = 6'(pos);
      end
      r.page_number = page;
      r.fault_count = faults_total;
      r.write_count = writes_total;
      r.flush_count = flushes_total;
      r.accumulator = acc_total;
      return r;
   endfunction

   task automatic report_mismatch(input string what, input logic [31:0] got,
                                  input logic [31:0] want);
      mismatch_count++;
      $display("mismatch at %0t: %s got %h expected %h", $time, what, got, want);
   endtask

   task automatic compare_result(input page_result_type got, input page_result_type want);
      if (got.hit !== want.hit) report_mismatch("hit", 32'(got.hit), 32'(want.hit));
      if (got.frame !== want.frame)
         report_mismatch("frame", 32'(got.frame), 32'(want.frame));
      if (got.flushed !== want.flushed)
         report_mismatch("flushed", 32'(got.flushed), 32'(want.flushed));
      if (got.page_number !== want.page_number)
         report_mismatch("page_number", got.page_number, want.page_number);
      if (got.fault_count !== want.fault_count)
         report_mismatch("fault_count", got.fault_count, want.fault_count);
      if (got.write_count !== want.write_count)
         report_mismatch("write_count", got.write_count, want.write_count);
      if (got.flush_count !== want.flush_count)
         report_mismatch("flush_count", got.flush_count, want.flush_count);
      if (got.accumulator !== want.accumulator)
         report_mismatch("accumulator", got.accumulator, want.accumulator);
   endtask

   // reference driver: next queued address once the previous one has transferred
   always @(negedge clock) begin : drive_refs
      logic offer;
      if (reset) begin
         req_bus.valid <= 1'b0;
      end else if (!req_bus.valid || req_fire) begin
         offer = pending_refs.size() != 0 && (quiet || $urandom_range(99) >= 28);
         if (offer) req_bus.address <= pending_refs.pop_front();
         req_bus.valid <= offer;
      end
   end

   // result side ready, with a long hold-off whenever the stimulus asks for one
   always @(negedge clock) begin : drive_ready
      if (reset) begin
         rsp_bus.ready <= 1'b0;
      end else if (hold_left > 0) begin
         rsp_bus.ready <= 1'b0;
         hold_left <= hold_left - 1;
      end else if (holds_served != holds_asked) begin
         rsp_bus.ready <= 1'b0;
         hold_left <= HOLD_CYCLES;
         holds_served <= holds_served + 1;
      end else begin
         rsp_bus.ready <= quiet || $urandom_range(99) >= 28;
      end
   end

   // monitor: predict on each reference transfer, check each result transfer
   always @(posedge clock) begin : watch_transfers
      page_result_type got;
      if (reset) begin
         req_fire <= 1'b0;
      end else begin
         req_fire <= req_bus.valid && req_bus.ready;
         if (req_bus.valid && req_bus.ready) begin
            expected_results.push_back(predict_reference(req_bus.address));
            refs_accepted++;
         end
         if (rsp_bus.valid && rsp_bus.ready) begin
            got.hit = rsp_bus.hit;
            got.frame = rsp_bus.frame;
            got.flushed = rsp_bus.flushed;
            got.page_number = rsp_bus.page_number;
            got.fault_count = rsp_bus.fault_count;
            got.write_count = rsp_bus.write_count;
            got.flush_count = rsp_bus.flush_count;
            got.accumulator = rsp_bus.accumulator;
            if (got.hit === 1'b1) hits_seen++;
            if (got.flushed === 1'b1) flushes_seen++;
            if (expected_results.size() == 0) begin
               report_mismatch("unexpected result, page_number", got.page_number, '0);
            end else begin
               compare_result(got, expected_results.pop_front());
               results_checked++;
            end
         end
      end
   end

   // register write with read-back, predictor copy updated at the write
   task automatic csr_write(input logic [scpr_pkg::PADDR_W-1:0] addr,
                            input logic [31:0] value);
      @(negedge clock);
      psel <= 1'b1;
      penable <= 1'b0;
      pwrite <= 1'b1;
      paddr <= addr;
      pwdata <= value;
      @(negedge clock);
      penable <= 1'b1;
      do @(posedge clock); while (!pready);
      if (addr == ADDR_OFFSET_BITS) cfg_offset_bits = value[4:0];
      else cfg_frames = value[6:0];
      @(negedge clock);
      penable <= 1'b0;
      pwrite <= 1'b0;
      @(negedge clock);
      penable <= 1'b1;
      do @(posedge clock); while (!pready);
      if (prdata !== value) report_mismatch("register read-back", prdata, value);
      @(negedge clock);
      psel <= 1'b0;
      penable <= 1'b0;
   endtask

   task automatic queue_ref(input logic [31:0] addr);
      pending_refs.push_back(addr);
      refs_queued++;
   endtask

   // block idle: everything transferred and every result back
   task automatic wait_drained();
      while (refs_accepted != refs_queued || expected_results.size() != 0)
         @(negedge clock);
   endtask

   // new setting, then a working set slightly larger than the frames in use
   task automatic random_phase(input logic [4:0] offset_bits, input logic [6:0] frames,
                               input int count);
      logic [31:0] pool[$];
      logic [31:0] low_mask;
      int n;
      wait_drained();
      csr_write(ADDR_OFFSET_BITS, 32'(offset_bits));
      csr_write(ADDR_FRAMES_IN_USE, 32'(frames));
      n = usable_frames(frames);
      low_mask = (32'h1 << offset_bits) - 32'h1;
      repeat (n + $urandom_range(1, n / 2 + 2)) begin
         // small page numbers recur across settings and meet stale frames
         if ($urandom_range(1)) pool.push_back($urandom_range(40));
         else pool.push_back($urandom >> offset_bits);
      end
      repeat (count) begin
         if ($urandom_range(99) < 15) queue_ref($urandom);
         else queue_ref((pool[$urandom_range(pool.size() - 1)] << offset_bits)
                        | ($urandom & low_mask));
      end
   endtask

   initial begin : stimulus
      req_bus.valid = 1'b0;
      req_bus.address = '0;
      rsp_bus.ready = 1'b0;
      psel = 1'b0;
      penable = 1'b0;
      pwrite = 1'b0;
      paddr = '0;
      pwdata = '0;
      repeat (10) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // reset setting: operand extremes, every opcode, write hits, fills
      queue_ref(32'h0000_0000);
      queue_ref(32'h0000_003F);
      queue_ref(32'h0000_007F);
      queue_ref(32'h0000_0080);
      queue_ref(32'hFFFF_FFFF);
      queue_ref(32'hFFFF_FFBF);
      queue_ref(32'h0000_1040);
      queue_ref(32'h0000_20C0);
      queue_ref(32'h8000_0000);

      // shrink: hand now beyond the frames in use, dirty victim, full sweep back to start
      wait_drained();
      csr_write(ADDR_FRAMES_IN_USE, 32'd2);
      queue_ref(32'h0000_2080);
      queue_ref(32'h0000_3000);
      queue_ref(32'h0000_3000);
      queue_ref(32'h0000_4000);

      // grow again: page 2 now in two frames, the lower one wins
      wait_drained();
      csr_write(ADDR_FRAMES_IN_USE, 32'd64);
      queue_ref(32'h0000_2000);
      queue_ref(32'h5555_5555);
      queue_ref(32'hAAAA_AAAA);

      random_phase(5'd0, 7'd1, 80);
      random_phase(5'd31, 7'd2, 80);
      random_phase(5'd5, 7'd0, 60);
      random_phase(5'd7, 7'd127, 100);
      // no idling on either side for this one
      quiet = 1'b1;
      random_phase(5'd8, 7'd4, 120);
      wait_drained();
      quiet = 1'b0;
      random_phase(5'd20, 7'd8, 120);
      random_phase(5'd3, 7'd65, 80);
      // result side holds off while references keep coming
      quiet = 1'b1;
      random_phase(5'd16, 7'd3, 120);
      holds_asked++;
      wait_drained();
      quiet = 1'b0;
      random_phase(5'd11, 7'd16, 120);
      random_phase(5'd12, 7'd64, 80);

      wait_drained();
      repeat (DRAIN_CYCLES) @(posedge clock);
      $display("covered %0d references over 13 register settings, %0d results checked",
               refs_accepted, results_checked);
      $display("results seen: %0d hits, %0d dirty evictions, %0d mismatches",
               hits_seen, flushes_seen, mismatch_count);
      if (mismatch_count == 0) begin
         $display("end of test: clean");
      end else begin
         $display("end of test: mismatches");
      end
      $finish;
   end

   // watchdog
   initial begin : watchdog
      #16_000_000;
      $display("timeout with %0d results outstanding", expected_results.size());
      $display("end of test: mismatches");
      $finish;
   end

endmodule

// ===== files.f =====
design/scpr_pkg.sv
design/scpr_ifs.sv
design/scpr_ctrl.sv
design/scpr_dpath.sv
design/second_chance_page_replacer_unit.sv
bench/tb_second_chance_page_replacer_unit.sv
